// File: rtl/precision_landing_velocity_control_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the precision landing velocity controller
// Overlapping and next-cycle implications under a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef PRECISION_LANDING_VELOCITY_CONTROL_ASSERT_SVH
`define PRECISION_LANDING_VELOCITY_CONTROL_ASSERT_SVH

// condition implies consequence in the same cycle
`define PLVC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define PLVC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/plvc_pkg.sv
// ---------------------------------------------------------------------------
// Precision landing velocity controller package
// Shared codes, widths, and interface structs.
// ---------------------------------------------------------------------------
package plvc_pkg;

    // result status codes
    localparam logic [1:0] STAT_RUN  = 2'd0;
    localparam logic [1:0] STAT_OK   = 2'd1;
    localparam logic [1:0] STAT_FAIL = 2'd2;

    // command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_HOVER = 2'd1;
    localparam logic [1:0] CMD_SPEED = 2'd2;

    localparam int UNSEEN_W   = 17;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 46;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_DESCENT = 3'd0,
        CFG_RADIUS  = 3'd1,
        CFG_ZDONE   = 3'd2,
        CFG_GAIN    = 3'd3,
        CFG_LIMIT   = 3'd4,
        CFG_TIMEOUT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [14:0] descent;
        logic [22:0] radius;
        logic [22:0] zdone;
        logic [15:0] gain;
        logic [14:0] limit;
        logic [15:0] timeout;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_SQRT = 2'b01,
        OP_DIV  = 2'b10
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_rsp;

endpackage

// File: rtl/precision_landing_velocity_control.sv
// ---------------------------------------------------------------------------
// Precision landing velocity controller
// Proportional position control toward a marker with a horizontal speed limit.
// ---------------------------------------------------------------------------
// Usage:
//   One request per control period enters on the input channel (valid/stall)
//   and yields exactly one result on the output channel (valid/stall).
//   The block works on one request at a time; o_in_stall is high meanwhile.
//   Path through the sequencer, around one shared multiplier and one
//   iterative root/divide unit:
//     final status or marker unseen: straight to the output state
//     success, hover or descent: one 32-step root
//     horizontal speed, no limiting: that root plus the gain and limit products
//     horizontal speed, limited: also a second root and two
//     46-step divisions
//   A new request is taken only once the previous one has left the sequencer.
//   The output register frees the sequencer: a new request is taken while
//   a result still waits; only the final hand-over waits on i_out_stall.
//   Reset restores the default settings, clears the unseen counter and the
//   final status. Settings are written through i_cfg_we/i_cfg_index/i_cfg_data;
//   the user must write them only while the block is idle (not enforced here).
// ---------------------------------------------------------------------------
`include "precision_landing_velocity_control_assert.svh"

module precision_landing_velocity_control
    import plvc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [22:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_marker_seen,
    input  logic signed [22:0] i_marker_x,
    input  logic signed [22:0] i_marker_y,
    input  logic signed [22:0] i_marker_z,
    input  logic signed [22:0] i_drone_x,
    input  logic signed [22:0] i_drone_y,
    input  logic signed [22:0] i_drone_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [1:0]         o_command_kind,
    output logic signed [15:0] o_vel_x,
    output logic signed [15:0] o_vel_y,
    output logic signed [15:0] o_vel_z,
    output logic [23:0]        o_horizontal_distance,
    output logic signed [23:0] o_vertical_offset
);

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_HX   = 20'h00002,
        S_HY   = 20'h00004,
        S_HSQ  = 20'h00008,
        S_HW   = 20'h00010,
        S_DEC  = 20'h00020,
        S_GX   = 20'h00040,
        S_GY   = 20'h00080,
        S_MX2  = 20'h00100,
        S_MY2  = 20'h00200,
        S_LIM  = 20'h00400,
        S_CMP  = 20'h00800,
        S_MW   = 20'h01000,
        S_DXM  = 20'h02000,
        S_DXS  = 20'h04000,
        S_DXW  = 20'h08000,
        S_DYM  = 20'h10000,
        S_DYS  = 20'h20000,
        S_DYW  = 20'h40000,
        S_OUT  = 20'h80000
    } t_state;

    t_cfg      w_cfg;
    t_iter_req w_req;
    t_iter_rsp w_rsp;
    logic [63:0] w_rad;
    logic [31:0] w_dvs;
    logic [31:0] w_root;
    logic [31:0] w_quo;

    t_state r_state;
    logic [UNSEEN_W-1:0] r_unseen;
    logic [1:0]  r_final;

    logic [22:0] r_ax, r_ay, r_adz;
    logic        r_sx, r_sy;
    logic signed [23:0] r_dz;
    logic [23:0] r_hd;
    logic [30:0] r_mx, r_my;
    logic [31:0] r_m;
    logic [63:0] r_acc, r_prod;
    logic [31:0] n_mul_a, n_mul_b;

    logic [1:0]  r_res_status, r_res_kind;
    logic signed [15:0] r_res_vx, r_res_vy, r_res_vz;

    logic        r_ovalid;
    logic [1:0]  r_o_status, r_o_kind;
    logic signed [15:0] r_o_vx, r_o_vy, r_o_vz;
    logic [23:0] r_o_hd;
    logic signed [23:0] r_o_dz;

    logic signed [23:0] n_dx, n_dy, n_dz;
    logic [23:0] n_ax, n_ay, n_adz;
    logic [UNSEEN_W-1:0] n_unseen;
    logic        w_accept;

    // apply sign to a magnitude known to fit in 15 bits
    function automatic logic signed [15:0] f_signed(input logic [14:0] mag, input logic neg);
        logic signed [15:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    plvc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    plvc_iter u_iter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .i_rad  (w_rad),
        .i_dvs  (w_dvs),
        .o_rsp  (w_rsp),
        .o_root (w_root),
        .o_quo  (w_quo)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // offsets from the incoming request
    always_comb begin
        n_dx  = {i_marker_x[22], i_marker_x} - {i_drone_x[22], i_drone_x};
        n_dy  = {i_marker_y[22], i_marker_y} - {i_drone_y[22], i_drone_y};
        n_dz  = {i_marker_z[22], i_marker_z} - {i_drone_z[22], i_drone_z};
        n_ax  = n_dx[23] ? 24'(-n_dx) : 24'(n_dx);
        n_ay  = n_dy[23] ? 24'(-n_dy) : 24'(n_dy);
        n_adz = n_dz[23] ? 24'(-n_dz) : 24'(n_dz);
        n_unseen = (r_unseen == {UNSEEN_W{1'b1}}) ? r_unseen : r_unseen + 1'b1;
    end

    // select shared multiplier operands
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        case (r_state)
            S_HX:  begin n_mul_a = 32'(r_ax); n_mul_b = 32'(r_ax); end
            S_HY:  begin n_mul_a = 32'(r_ay); n_mul_b = 32'(r_ay); end
            S_GX:  begin n_mul_a = 32'(r_ax); n_mul_b = 32'(w_cfg.gain); end
            S_GY:  begin n_mul_a = 32'(r_ay); n_mul_b = 32'(w_cfg.gain); end
            S_MX2: begin n_mul_a = 32'(r_mx); n_mul_b = 32'(r_mx); end
            S_MY2: begin n_mul_a = 32'(r_my); n_mul_b = 32'(r_my); end
            S_LIM: begin n_mul_a = 32'(w_cfg.limit); n_mul_b = 32'(w_cfg.limit); end
            S_DXM: begin n_mul_a = 32'(r_mx); n_mul_b = 32'(w_cfg.limit); end
            S_DYM: begin n_mul_a = 32'(r_my); n_mul_b = 32'(w_cfg.limit); end
            default: ;
        endcase
    end

    // drive the root/divide unit
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = OP_SQRT;
        w_rad       = r_acc;
        w_dvs       = r_m;
        case (r_state)
            S_HSQ: begin
                w_req.start = 1'b1;
                w_rad       = r_acc + r_prod;
            end
            S_CMP: w_req.start = (r_acc > r_prod);
            S_DXS, S_DYS: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                w_rad       = {r_prod[45:0], 18'd0};
            end
            default: ;
        endcase
    end

    // register the product
    always_ff @(posedge i_clk) begin
        r_prod <= n_mul_a * n_mul_b;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_unseen <= '0;
            r_final  <= STAT_RUN;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_final != STAT_RUN) begin
                            r_state <= S_OUT;
                        end else if (!i_marker_seen) begin
                            r_unseen <= n_unseen;
                            if (n_unseen > UNSEEN_W'(w_cfg.timeout)) begin
                                r_final <= STAT_FAIL;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_unseen <= '0;
                            r_state  <= S_HX;
                        end
                    end
                end
                S_HX:  r_state <= S_HY;
                S_HY:  r_state <= S_HSQ;
                S_HSQ: r_state <= S_HW;
                S_HW:  if (w_rsp.done) r_state <= S_DEC;
                S_DEC: begin
                    if ({1'b0, r_adz} < {1'b0, w_cfg.zdone}) begin
                        r_final <= STAT_OK;
                        r_state <= S_OUT;
                    end else if (r_hd > {1'b0, w_cfg.radius}) begin
                        r_state <= S_GX;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_GX:  r_state <= S_GY;
                S_GY:  r_state <= S_MX2;
                S_MX2: r_state <= S_MY2;
                S_MY2: r_state <= S_LIM;
                S_LIM: r_state <= S_CMP;
                S_CMP: r_state <= (r_acc > r_prod) ? S_MW : S_OUT;
                S_MW:  if (w_rsp.done) r_state <= S_DXM;
                S_DXM: r_state <= S_DXS;
                S_DXS: r_state <= S_DXW;
                S_DXW: if (w_rsp.done) r_state <= S_DYM;
                S_DYM: r_state <= S_DYS;
                S_DYS: r_state <= S_DYW;
                S_DYW: if (w_rsp.done) r_state <= S_OUT;
                S_OUT: if (!r_ovalid || !i_out_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers and staged result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ax  <= n_ax[22:0];
                r_ay  <= n_ay[22:0];
                r_adz <= n_adz[22:0];
                r_sx  <= n_dx[23];
                r_sy  <= n_dy[23];
                r_dz  <= n_dz;
                r_res_vx <= '0;
                r_res_vy <= '0;
                r_res_vz <= '0;
                r_hd     <= '0;
                if (r_final != STAT_RUN) begin
                    r_res_status <= r_final;
                    r_res_kind   <= CMD_NONE;
                    r_dz         <= '0;
                end else if (!i_marker_seen) begin
                    r_dz <= '0;
                    if (n_unseen > UNSEEN_W'(w_cfg.timeout)) begin
                        r_res_status <= STAT_FAIL;
                        r_res_kind   <= CMD_NONE;
                    end else begin
                        r_res_status <= STAT_RUN;
                        r_res_kind   <= CMD_HOVER;
                    end
                end
            end
            S_HY:  r_acc <= r_prod;
            S_HW:  if (w_rsp.done) r_hd <= w_root[23:0];
            S_DEC: begin
                if ({1'b0, r_adz} < {1'b0, w_cfg.zdone}) begin
                    r_res_status <= STAT_OK;
                    r_res_kind   <= CMD_HOVER;
                end else begin
                    r_res_status <= STAT_RUN;
                    r_res_kind   <= CMD_SPEED;
                    if (!(r_hd > {1'b0, w_cfg.radius})) begin
                        r_res_vz <= -$signed({1'b0, w_cfg.descent});
                    end
                end
            end
            S_GY:  r_mx  <= r_prod[38:8];
            S_MX2: r_my  <= r_prod[38:8];
            S_MY2: r_acc <= r_prod;
            S_LIM: r_acc <= r_acc + r_prod;
            S_CMP: begin
                r_res_vx <= f_signed(r_mx[14:0], r_sx);
                r_res_vy <= f_signed(r_my[14:0], r_sy);
            end
            S_MW:  if (w_rsp.done) r_m <= w_root;
            S_DXW: if (w_rsp.done) r_mx <= w_quo[30:0];
            S_DYW: begin
                if (w_rsp.done) begin
                    r_res_vx <= f_signed(r_mx[14:0], r_sx);
                    r_res_vy <= f_signed(w_quo[14:0], r_sy);
                end
            end
            default: ;
        endcase
    end

    // output register: load on hand-over, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && (!r_ovalid || !i_out_stall)) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || !i_out_stall)) begin
            r_o_status <= r_res_status;
            r_o_kind   <= r_res_kind;
            r_o_vx     <= r_res_vx;
            r_o_vy     <= r_res_vy;
            r_o_vz     <= r_res_vz;
            r_o_hd     <= r_hd;
            r_o_dz     <= r_dz;
        end
    end

    assign o_out_valid           = r_ovalid;
    assign o_status              = r_o_status;
    assign o_command_kind        = r_o_kind;
    assign o_vel_x               = r_o_vx;
    assign o_vel_y               = r_o_vy;
    assign o_vel_z               = r_o_vz;
    assign o_horizontal_distance = r_o_hd;
    assign o_vertical_offset     = r_o_dz;

    // a final status never changes until reset
    `PLVC_ASSERT_NEXT(a_final_hold, i_clk, i_rst_n, r_final != STAT_RUN, r_final == $past(r_final))
    // an accepted request blocks the next one
    `PLVC_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_accept, o_in_stall)
    // the root/divide unit is started only when free
    `PLVC_ASSERT_IMPL(a_iter_free, i_clk, i_rst_n, w_req.start, !w_rsp.busy)

endmodule

// File: rtl/plvc_cfg.sv
// ---------------------------------------------------------------------------
// Configuration register file
// Holds the controller settings, written through a plain write port.
// ---------------------------------------------------------------------------
module plvc_cfg
    import plvc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.descent <= 15'd500;
            r_cfg.radius  <= 23'd300;
            r_cfg.zdone   <= 23'd100;
            r_cfg.gain    <= 16'd256;
            r_cfg.limit   <= 15'd1000;
            r_cfg.timeout <= 16'd50;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DESCENT: r_cfg.descent <= i_cfg_data[14:0];
                CFG_RADIUS:  r_cfg.radius  <= i_cfg_data;
                CFG_ZDONE:   r_cfg.zdone   <= i_cfg_data;
                CFG_GAIN:    r_cfg.gain    <= i_cfg_data[15:0];
                CFG_LIMIT:   r_cfg.limit   <= i_cfg_data[14:0];
                CFG_TIMEOUT: r_cfg.timeout <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/plvc_iter.sv
// ---------------------------------------------------------------------------
// Iterative root and divide unit
// Restoring square root (two radicand bits a cycle) or division (one bit a cycle).
// ---------------------------------------------------------------------------
module plvc_iter
    import plvc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_iter_req   i_req,
    input  logic [63:0] i_rad,
    input  logic [31:0] i_dvs,
    output t_iter_rsp   o_rsp,
    output logic [31:0] o_root,
    output logic [31:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    t_iter_op    r_op;
    logic [63:0] r_rad;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [31:0] r_dvs;

    logic [35:0] n_sq_sh;
    logic [35:0] n_sq_trial;
    logic [35:0] n_dv_sh;
    logic [35:0] n_dv_dvs;

    always_comb begin
        n_sq_sh    = {r_rem[33:0], r_rad[63:62]};
        n_sq_trial = {2'b00, r_root, 2'b01};
        n_dv_sh    = {r_rem[34:0], r_rad[63]};
        n_dv_dvs   = {4'b0000, r_dvs};
    end

    // control: load on start, count steps, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_SQRT;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == OP_DIV) ? 6'(DIV_STEPS - 1) : 6'(SQRT_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    // datapath: one step per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rad  <= i_rad;
            r_dvs  <= i_dvs;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            if (r_op == OP_DIV) begin
                if (n_dv_sh >= n_dv_dvs) begin
                    r_rem <= n_dv_sh - n_dv_dvs;
                    r_rad <= {r_rad[62:0], 1'b1};
                end else begin
                    r_rem <= n_dv_sh;
                    r_rad <= {r_rad[62:0], 1'b0};
                end
            end else begin
                r_rad <= {r_rad[61:0], 2'b00};
                if (n_sq_sh >= n_sq_trial) begin
                    r_rem  <= n_sq_sh - n_sq_trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= n_sq_sh;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_root     = r_root;
    assign o_quo      = r_rad[31:0];

endmodule
